// File: sv/pbb_pkg.sv
package pbb_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned CellW     = 32;
  localparam int unsigned SizeW     = 31;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned StepCntW  = $clog2(DivSteps);

  localparam logic [CellW-1:0] CellSizeReset = 32'h0001_0000;
  localparam logic [SizeW-1:0] SizeMax       = {SizeW{1'b1}};
  localparam logic [SizeW-1:0] SizeOne       = {{(SizeW-1){1'b0}}, 1'b1};

  localparam logic StatusOk      = 1'b0;
  localparam logic StatusBadCell = 1'b1;

  typedef enum logic [3:0] {
    ST_ACCUM = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_WB    = 4'b1000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // point transfer this cycle
    logic seed;       // point starts a new box
    logic load;       // load dividers with extents
    logic step;       // one division step
    logic write_out;  // capture result into output register
  } cmd_t;

endpackage

// File: sv/pbb_div.sv
// Restoring divider, one quotient bit per step, with ceiling and clamp on the result.
module pbb_div (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic                        step_i,
  input  logic [pbb_pkg::CoordW-1:0]  extent_i,
  input  logic [pbb_pkg::CellW-1:0]   cell_i,
  output logic [pbb_pkg::SizeW-1:0]   cells_o
);
  import pbb_pkg::*;

  logic [CoordW-1:0] quo_q, quo_d;
  logic [CellW-1:0]  rem_q, rem_d;
  logic [CellW:0]    rem_sh;
  logic [CellW:0]    rem_sub;
  logic              fits;
  logic [CoordW:0]   ceil_sum;

  always_comb begin
    rem_sh  = {rem_q, quo_q[CoordW-1]};
    rem_sub = rem_sh - {1'b0, cell_i};
    fits    = (rem_sh >= {1'b0, cell_i});
    quo_d   = quo_q;
    rem_d   = rem_q;
    if (load_i) begin
      quo_d = extent_i;
      rem_d = '0;
    end else if (step_i) begin
      quo_d = {quo_q[CoordW-2:0], fits};
      rem_d = fits ? rem_sub[CellW-1:0] : rem_sh[CellW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  always_comb begin
    ceil_sum = {1'b0, quo_q} + {{CoordW{1'b0}}, (rem_q != '0)};
    if (ceil_sum == '0) begin
      cells_o = SizeOne;
    end else if (ceil_sum[CoordW:SizeW] != '0) begin
      cells_o = SizeMax;
    end else begin
      cells_o = ceil_sum[SizeW-1:0];
    end
  end

endmodule

// File: sv/pbb_dpath.sv
// Bounds registers, cell size register, two divider lanes, output register.
module pbb_dpath (
  input  logic                        clk_i,
  input  pbb_pkg::cmd_t               cmd_i,
  input  logic                        cell_size_we_i,
  input  logic [pbb_pkg::CellW-1:0]   cell_size_i,
  input  logic [pbb_pkg::CoordW-1:0]  point_x_i,
  input  logic [pbb_pkg::CoordW-1:0]  point_y_i,
  output logic [pbb_pkg::CoordW-1:0]  origin_x_o,
  output logic [pbb_pkg::CoordW-1:0]  origin_y_o,
  output logic [pbb_pkg::SizeW-1:0]   width_cells_o,
  output logic [pbb_pkg::SizeW-1:0]   height_cells_o,
  output logic                        status_o,
  input  logic                        rst_ni
);
  import pbb_pkg::*;

  logic signed [CoordW-1:0] low_x_q, low_y_q, high_x_q, high_y_q;
  logic signed [CoordW-1:0] px, py;
  logic [CellW-1:0]         cell_q;
  logic [CoordW-1:0]        ext_x, ext_y;
  logic [SizeW-1:0]         cells_x, cells_y;
  logic                     bad_cell;

  assign px = point_x_i;
  assign py = point_y_i;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= CellSizeReset;
    end else if (cell_size_we_i) begin
      cell_q <= cell_size_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (cmd_i.seed) begin
        low_x_q  <= px;
        high_x_q <= px;
        low_y_q  <= py;
        high_y_q <= py;
      end else begin
        if (px < low_x_q)  low_x_q  <= px;
        if (px > high_x_q) high_x_q <= px;
        if (py < low_y_q)  low_y_q  <= py;
        if (py > high_y_q) high_y_q <= py;
      end
    end
  end

  // hi >= lo, so the modulo-2^32 difference is the exact unsigned extent
  assign ext_x = high_x_q - low_x_q;
  assign ext_y = high_y_q - low_y_q;

  pbb_div u_div_x (
    .clk_i    (clk_i),
    .load_i   (cmd_i.load),
    .step_i   (cmd_i.step),
    .extent_i (ext_x),
    .cell_i   (cell_q),
    .cells_o  (cells_x)
  );

  pbb_div u_div_y (
    .clk_i    (clk_i),
    .load_i   (cmd_i.load),
    .step_i   (cmd_i.step),
    .extent_i (ext_y),
    .cell_i   (cell_q),
    .cells_o  (cells_y)
  );

  assign bad_cell = (cell_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_out) begin
      origin_x_o     <= low_x_q;
      origin_y_o     <= low_y_q;
      width_cells_o  <= bad_cell ? '0 : cells_x;
      height_cells_o <= bad_cell ? '0 : cells_y;
      status_o       <= bad_cell ? StatusBadCell : StatusOk;
    end
  end

endmodule

// File: sv/pbb_ctrl.sv
// Sequencer: point intake, divide pass, output register valid.
module pbb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           last_point_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pbb_pkg::cmd_t  cmd_o
);
  import pbb_pkg::*;

  state_e              state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic                first_q, first_d;
  logic                out_valid_q, out_valid_d;
  logic                in_xfer, out_xfer, out_free;

  assign in_stall_o  = (state_q != ST_ACCUM);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    first_d     = first_q;
    cmd_o       = '0;
    cmd_o.accept = in_xfer;
    cmd_o.seed   = first_q;
    out_valid_d = out_xfer ? 1'b0 : out_valid_q;
    case (state_q)
      ST_ACCUM: begin
        if (in_xfer) begin
          first_d = last_point_i;
          if (last_point_i) state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d      = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == StepCntW'(DivSteps - 1)) state_d = ST_WB;
      end
      ST_WB: begin
        if (out_free) begin
          cmd_o.write_out = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      cnt_q       <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: sv/point_bounding_box_grid_size.sv
// Points that are not marked last transfer one per cycle while in_stall_o is low, and give no result.
// The point marked last starts a pass (load, 32 divide steps, write back once the output
// register is free); its result becomes valid at the write back. No point is taken during it.
// The bit-serial dividers set the pace: no point of the next cloud is taken until the pass is done.
// Reset (rst_ni low, async): no result pending, next point seeds the box, cell size 1.0.
module point_bounding_box_grid_size (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // cell size register (unsigned Q16.16)
  input  logic                         cell_size_we_i,
  input  logic [pbb_pkg::CellW-1:0]    cell_size_i,
  // point input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [pbb_pkg::CoordW-1:0] point_x_i,
  input  logic signed [pbb_pkg::CoordW-1:0] point_y_i,
  input  logic                         last_point_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [pbb_pkg::CoordW-1:0] origin_x_o,
  output logic signed [pbb_pkg::CoordW-1:0] origin_y_o,
  output logic [pbb_pkg::SizeW-1:0]    width_cells_o,
  output logic [pbb_pkg::SizeW-1:0]    height_cells_o,
  output logic                         status_o
);
  import pbb_pkg::*;

  cmd_t cmd;

  // Controller: one-hot FSM. ACCUM takes point transfers, LOAD latches both
  // extents into the dividers, DIV runs the 32 quotient steps, WB waits for
  // the output register to be free. The output register decouples the result
  // side, so a finished result may sit there while the next cloud streams in.
  pbb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_point_i (last_point_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cmd_o        (cmd)
  );

  // Datapath: running min/max (one signed compare per bound per cycle),
  // then ceil(extent / cell) on two restoring dividers in parallel.
  // Zero extent yields 1 cell, over 2^31-1 saturates; zero cell size flags
  // status and forces both sizes to 0 while origin still carries the minima.
  pbb_dpath u_dpath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .cell_size_we_i (cell_size_we_i),
    .cell_size_i    (cell_size_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .origin_x_o     (origin_x_o),
    .origin_y_o     (origin_y_o),
    .width_cells_o  (width_cells_o),
    .height_cells_o (height_cells_o),
    .status_o       (status_o),
    .rst_ni         (rst_ni)
  );

endmodule

// File: dv/tb_point_bounding_box_grid_size.sv
module tb_point_bounding_box_grid_size;
  import pbb_pkg::*;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [CellW-1:0]         cell_t;
  typedef logic [SizeW-1:0]         size_t;

  // One grid description, as the block emits it on the last point of a cloud.
  typedef struct packed {
    coord_t corner_x;
    coord_t corner_y;
    size_t  width_cells;
    size_t  height_cells;
    logic   status;
  } grid_t;

  // Directed stimulus row. wr: load cell size first (block drained).
  // typed: push res as the expectation instead of the predicted grid.
  typedef struct packed {
    logic   wr;
    cell_t  cell_val;
    coord_t x;
    coord_t y;
    logic   last;
    logic   typed;
    grid_t  res;
  } dir_row_t;

  localparam int ResetCycles = 9;
  localparam int DrainCycles = 40;    // divide pass plus margin
  localparam int StallLimit  = 2000;  // cycles with no transfer on either channel
  localparam int HoldCycles  = 300;   // long receiver hold-off, fills the block
  localparam int HoldAfter   = 30;    // results taken before that hold-off
  localparam int SegItems    = 105;   // minimum points per cell size setting
  localparam int NumPhases   = 3;
  localparam int SegsPerPhase = 4;

  localparam coord_t CMin = 32'sh8000_0000;
  localparam coord_t CMax = 32'sh7fff_ffff;
  localparam grid_t  NoRes = '0;

  localparam int NumDir = 23;
  localparam dir_row_t DirTab [NumDir] = '{
    // reset cell size (1.0): single points give a 1x1 grid
    '{1'b0, 32'h0, 32'sd0, 32'sd0, 1'b1, 1'b1,
      '{32'sd0, 32'sd0, 31'd1, 31'd1, StatusOk}},
    '{1'b0, 32'h0, CMax, CMin, 1'b1, 1'b1,
      '{CMax, CMin, 31'd1, 31'd1, StatusOk}},
    // full-range extent over 1.0: (2^32-1)/2^16 rounds up to 65536
    '{1'b0, 32'h0, CMin, CMin, 1'b0, 1'b0, NoRes},
    '{1'b0, 32'h0, CMax, CMax, 1'b1, 1'b1,
      '{CMin, CMin, 31'd65536, 31'd65536, StatusOk}},
    // fractional coordinates, predicted
    '{1'b0, 32'h0, 32'sh0001_8000, -32'sh0002_4000, 1'b0, 1'b0, NoRes},
    '{1'b0, 32'h0, -32'sh0000_4000, 32'sh0003_0000, 1'b0, 1'b0, NoRes},
    '{1'b0, 32'h0, 32'sh0000_c000, 32'sh0000_0001, 1'b1, 1'b0, NoRes},
    // smallest cell size: full extent saturates
    '{1'b1, 32'h1, CMin, CMin, 1'b0, 1'b0, NoRes},
    '{1'b0, 32'h0, CMax, CMax, 1'b1, 1'b1,
      '{CMin, CMin, SizeMax, SizeMax, StatusOk}},
    // flat cloud: zero extent is raised to one cell
    '{1'b0, 32'h0, 32'sd5, 32'sd5, 1'b0, 1'b0, NoRes},
    '{1'b0, 32'h0, 32'sd5, 32'sd5, 1'b1, 1'b1,
      '{32'sd5, 32'sd5, 31'd1, 31'd1, StatusOk}},
    // zero cell size: error status, sizes 0, minima still reported
    '{1'b1, 32'h0, 32'sd3, -32'sd3, 1'b0, 1'b0, NoRes},
    '{1'b0, 32'h0, -32'sd7, 32'sd9, 1'b1, 1'b1,
      '{-32'sd7, -32'sd3, 31'd0, 31'd0, StatusBadCell}},
    '{1'b0, 32'h0, CMax, CMax, 1'b1, 1'b1,
      '{CMax, CMax, 31'd0, 31'd0, StatusBadCell}},
    // largest cell size: everything fits in one cell
    '{1'b1, 32'hffff_ffff, CMin, CMin, 1'b0, 1'b0, NoRes},
    '{1'b0, 32'h0, CMax, CMax, 1'b1, 1'b1,
      '{CMin, CMin, 31'd1, 31'd1, StatusOk}},
    '{1'b0, 32'h0, 32'sd0, 32'sd0, 1'b0, 1'b0, NoRes},
    '{1'b0, 32'h0, 32'sd1, 32'sd1, 1'b1, 1'b1,
      '{32'sd0, 32'sd0, 31'd1, 31'd1, StatusOk}},
    // cell 2^31: extent just above one cell rounds up to two
    '{1'b1, 32'h8000_0000, 32'sd0, 32'sd0, 1'b0, 1'b0, NoRes},
    '{1'b0, 32'h0, CMin, 32'sd0, 1'b0, 1'b0, NoRes},
    '{1'b0, 32'h0, 32'sd1, 32'sd1, 1'b1, 1'b0, NoRes},
    // odd tiny cell size, predicted
    '{1'b1, 32'h3, -32'sd10, 32'sd7, 1'b0, 1'b0, NoRes},
    '{1'b0, 32'h0, 32'sd20, -32'sd8, 1'b1, 1'b0, NoRes}
  };

  logic   clk_i;
  logic   rst_ni;
  logic   cell_size_we_i;
  cell_t  cell_size_i;
  logic   in_valid_i;
  logic   in_stall_o;
  coord_t point_x_i;
  coord_t point_y_i;
  logic   last_point_i;
  logic   out_valid_o;
  logic   out_stall_i;
  coord_t origin_x_o;
  coord_t origin_y_o;
  size_t  width_cells_o;
  size_t  height_cells_o;
  logic   status_o;

  point_bounding_box_grid_size u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cell_size_we_i (cell_size_we_i),
    .cell_size_i    (cell_size_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .last_point_i   (last_point_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .origin_x_o     (origin_x_o),
    .origin_y_o     (origin_y_o),
    .width_cells_o  (width_cells_o),
    .height_cells_o (height_cells_o),
    .status_o       (status_o)
  );

  // Predicted box state, mirrors the block's running min/max.
  coord_t box_lo_x, box_lo_y, box_hi_x, box_hi_y;
  bit     seed_next = 1'b1;          // next point starts a new cloud
  cell_t  cell_now  = CellSizeReset; // cell size the block holds

  grid_t  pending_grids [$];         // grids still to come out, oldest first

  int     fails        = 0;
  int     results_seen = 0;
  int     snd_idle_pct = 0;          // chance per transfer of an idle cycle
  int     rcv_idle_pct = 0;          // chance per cycle of a stall

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ceil(extent / cell), at least 1, saturating; exact in 64 bits
  function automatic size_t cells_over(input coord_t lo, input coord_t hi);
    longint unsigned span;
    longint unsigned n;
    span = longint'(hi) - longint'(lo);
    n = (span + 64'(cell_now) - 64'd1) / 64'(cell_now);
    if (n == 0) n = 1;
    if (n > 64'(SizeMax)) n = 64'(SizeMax);
    return size_t'(n);
  endfunction

  // Fold one point into the box; returns 1 and the grid on a last point.
  function automatic bit track_point(input coord_t x, input coord_t y, input logic last,
                                     output grid_t g);
    g = '0;
    if (seed_next) begin
      box_lo_x = x;
      box_hi_x = x;
      box_lo_y = y;
      box_hi_y = y;
      seed_next = 1'b0;
    end else begin
      if (x < box_lo_x) box_lo_x = x;
      if (x > box_hi_x) box_hi_x = x;
      if (y < box_lo_y) box_lo_y = y;
      if (y > box_hi_y) box_hi_y = y;
    end
    if (!last) return 1'b0;
    g.corner_x = box_lo_x;
    g.corner_y = box_lo_y;
    if (cell_now == '0) begin
      g.status = StatusBadCell;  // sizes stay 0
    end else begin
      g.width_cells  = cells_over(box_lo_x, box_hi_x);
      g.height_cells = cells_over(box_lo_y, box_hi_y);
      g.status       = StatusOk;
    end
    seed_next = 1'b1;
    return 1'b1;
  endfunction

  // Offer one point; returns at the edge that takes the transfer.
  task automatic send_point(input coord_t x, input coord_t y, input logic last,
                            input logic typed, input grid_t typed_res);
    grid_t g;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    point_x_i    <= x;
    point_y_i    <= y;
    last_point_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (track_point(x, y, last, g)) pending_grids.push_back(typed ? typed_res : g);
  endtask

  // Sender stops until all grids are out and the divider has had time to finish.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_grids.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cell(input cell_t v);
    cell_size_we_i <= 1'b1;
    cell_size_i    <= v;
    @(posedge clk_i);
    cell_size_we_i <= 1'b0;
    cell_now = v;
  endtask

  // mode 0-2: anywhere; 3-7: clustered near c; 8-9: range ends, zero or c
  function automatic coord_t pick_coord(input int mode, input coord_t c, input int spread);
    if (mode < 3) return coord_t'($urandom);
    if (mode < 8) return c + coord_t'($urandom & ((32'd1 << spread) - 32'd1));
    case ($urandom_range(3))
      0:       return CMin;
      1:       return CMax;
      2:       return '0;
      default: return c;
    endcase
  endfunction

  function automatic cell_t pick_cell();
    case ($urandom_range(5))
      0:       return cell_t'($urandom);
      1:       return cell_t'($urandom_range(1, 16));
      2:       return cell_t'(($urandom_range(1, 8) << 16) | ($urandom & 32'hffff));
      3:       return '0;
      4:       return ($urandom_range(1) != 0) ? 32'hffff_ffff : 32'h8000_0000;
      default: return cell_t'($urandom >> $urandom_range(31));
    endcase
  endfunction

  // One cloud of random length, mostly short; n returns its size.
  task automatic send_cloud(output int n);
    int unsigned pick;
    int          mode;
    int          spread;
    coord_t      cx, cy;
    int          i;
    pick   = $urandom_range(99);
    n      = (pick < 70) ? $urandom_range(1, 6) :
             (pick < 95) ? $urandom_range(7, 20) : $urandom_range(21, 60);
    mode   = $urandom_range(9);
    spread = $urandom_range(24);
    cx     = coord_t'($urandom);
    cy     = coord_t'($urandom);
    for (i = 0; i < n; i++) begin
      send_point(pick_coord(mode, cx, spread), pick_coord(mode, cy, spread),
                 i == n - 1, 1'b0, NoRes);
    end
  endtask

  // Stimulus: reset, directed table, then random clouds over three idle profiles.
  initial begin
    int i;
    int p;
    int s;
    int done;
    int n;
    rst_ni         <= 1'b0;
    cell_size_we_i <= 1'b0;
    cell_size_i    <= CellSizeReset;
    in_valid_i     <= 1'b0;
    point_x_i      <= '0;
    point_y_i      <= '0;
    last_point_i   <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (p = 0; p < NumPhases; p++) begin
      // sender mostly busy / receiver mostly stalled, then swapped, then no idling
      snd_idle_pct = (p == 0) ? 10 : (p == 1) ? 71 : 0;
      rcv_idle_pct = (p == 0) ? 71 : (p == 1) ? 10 : 0;
      if (p == 0) begin
        for (i = 0; i < NumDir; i++) begin
          if (DirTab[i].wr) begin
            wait_idle();
            write_cell(DirTab[i].cell_val);
          end
          send_point(DirTab[i].x, DirTab[i].y, DirTab[i].last,
                     DirTab[i].typed, DirTab[i].res);
        end
      end
      for (s = 0; s < SegsPerPhase; s++) begin
        wait_idle();
        write_cell(pick_cell());
        done = 0;
        while (done < SegItems) begin
          send_cloud(n);
          done += n;
        end
      end
    end

    wait_idle();
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  task automatic check_grid(input grid_t want, input grid_t got);
    if (got.corner_x !== want.corner_x) begin
      $error("origin_x_o: expected %0d, got %0d", want.corner_x, got.corner_x);
      fails++;
    end
    if (got.corner_y !== want.corner_y) begin
      $error("origin_y_o: expected %0d, got %0d", want.corner_y, got.corner_y);
      fails++;
    end
    if (got.width_cells !== want.width_cells) begin
      $error("width_cells: expected %0d, got %0d", want.width_cells, got.width_cells);
      fails++;
    end
    if (got.height_cells !== want.height_cells) begin
      $error("height_cells: expected %0d, got %0d", want.height_cells, got.height_cells);
      fails++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fails++;
    end
  endtask

  // Receiver: check each result transfer, then pick next cycle's stall.
  initial begin
    grid_t got;
    int    hold_left;
    bit    held;
    hold_left = 0;
    held      = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got = '{origin_x_o, origin_y_o, width_cells_o, height_cells_o, status_o};
        if (pending_grids.size() == 0) begin
          $error("result transfer with none expected: origin %0d,%0d size %0dx%0d",
                 origin_x_o, origin_y_o, width_cells_o, height_cells_o);
          fails++;
        end else begin
          check_grid(pending_grids.pop_front(), got);
        end
        results_seen++;
      end
      // one long hold-off: block backs up and stalls its point input
      if (!held && results_seen == HoldAfter) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
      end
    end
  end

  // Watchdog: too long without a transfer on either channel.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
